// ----- rtl/pidc_pkg.sv -----
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared widths, control word layout and microcode program of the clamped
// PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

    localparam int MEAS_W     = 16;
    localparam int MS_W       = 16;
    localparam int GAIN_W     = 32;
    localparam int LIM_W      = 16;
    localparam int FRAC_W     = 16;
    localparam int Q_W        = LIM_W + FRAC_W;
    localparam int ERR_W      = MEAS_W + 1;
    localparam int WIDE_W     = 64;
    localparam int MUL_A_W    = GAIN_W + ERR_W;
    localparam int MUL_B_W    = ERR_W;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MS_PER_S   = 1000;
    localparam int ROUND_HALF = 1 << (FRAC_W - 1);

    // divider: 4 quotient bits per cycle
    localparam int DIV_BITS   = 4;
    localparam int DIV_STEPS  = WIDE_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam int PC_W       = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P  = 3'd0,
        REG_GAIN_I  = 3'd1,
        REG_GAIN_D  = 3'd2,
        REG_OUT_MIN = 3'd3,
        REG_OUT_MAX = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        C_NEXT     = 3'd0,
        C_JUMP     = 3'd1,
        C_WAIT_IN  = 3'd2,
        C_WAIT_DIV = 3'd3,
        C_SKIP_KI  = 3'd4,
        C_SKIP_D   = 3'd5,
        C_WAIT_OUT = 3'd6
    } cond_t;

    typedef enum logic [1:0] {
        MA_KP   = 2'd0,
        MA_KI   = 2'd1,
        MA_KD   = 2'd2,
        MA_PROD = 2'd3
    } mul_a_t;

    typedef enum logic [1:0] {
        MB_ERR   = 2'd0,
        MB_MS    = 2'd1,
        MB_DI    = 2'd2,
        MB_K1000 = 2'd3
    } mul_b_t;

    typedef enum logic {
        DEN_1000 = 1'b0,
        DEN_MS   = 1'b1
    } den_t;

    typedef enum logic [1:0] {
        ACC_HOLD   = 2'd0,
        ACC_LOAD_P = 2'd1,
        ACC_ADD_I  = 2'd2,
        ACC_SUB_Q  = 2'd3
    } acc_op_t;

    typedef enum logic [1:0] {
        INT_HOLD  = 2'd0,
        INT_CLAMP = 2'd1,
        INT_ZERO  = 2'd2
    } int_op_t;

    typedef struct packed {
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic            take_in;
        logic            mul_en;
        mul_a_t          mul_a;
        mul_b_t          mul_b;
        logic            div_start;
        den_t            div_den;
        acc_op_t         acc_op;
        int_op_t         int_op;
        logic            out_load;
    } ctrl_word_t;

    typedef struct packed {
        logic in_valid;
        logic div_busy;
        logic ki_zero;
        logic d_skip;
        logic out_busy;
    } pidc_status_t;

    localparam logic [PC_W-1:0] STEP_LOAD      = 4'd0;
    localparam logic [PC_W-1:0] STEP_MUL_P     = 4'd1;
    localparam logic [PC_W-1:0] STEP_MUL_KI    = 4'd2;
    localparam logic [PC_W-1:0] STEP_MUL_IE    = 4'd3;
    localparam logic [PC_W-1:0] STEP_DIV_I     = 4'd4;
    localparam logic [PC_W-1:0] STEP_WAIT_I    = 4'd5;
    localparam logic [PC_W-1:0] STEP_INT_CLAMP = 4'd6;
    localparam logic [PC_W-1:0] STEP_INT_ADD   = 4'd7;
    localparam logic [PC_W-1:0] STEP_MUL_D     = 4'd8;
    localparam logic [PC_W-1:0] STEP_MUL_K     = 4'd9;
    localparam logic [PC_W-1:0] STEP_DIV_D     = 4'd10;
    localparam logic [PC_W-1:0] STEP_WAIT_D    = 4'd11;
    localparam logic [PC_W-1:0] STEP_D_SUB     = 4'd12;
    localparam logic [PC_W-1:0] STEP_OUT       = 4'd13;
    localparam logic [PC_W-1:0] STEP_INT_ZERO  = 4'd14;

    function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] addr);
        ctrl_word_t w;
        w = '0;
        unique case (addr)
            STEP_LOAD: begin
                w.cond    = C_WAIT_IN;
                w.take_in = 1'b1;
            end
            STEP_MUL_P: begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_KP;
                w.mul_b  = MB_ERR;
            end
            STEP_MUL_KI: begin
                w.cond   = C_SKIP_KI;
                w.target = STEP_INT_ZERO;
                w.acc_op = ACC_LOAD_P;
                w.mul_en = 1'b1;
                w.mul_a  = MA_KI;
                w.mul_b  = MB_MS;
            end
            STEP_MUL_IE: begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_PROD;
                w.mul_b  = MB_ERR;
            end
            STEP_DIV_I: begin
                w.div_start = 1'b1;
                w.div_den   = DEN_1000;
            end
            STEP_WAIT_I: begin
                w.cond = C_WAIT_DIV;
            end
            STEP_INT_CLAMP: begin
                w.int_op = INT_CLAMP;
            end
            STEP_INT_ADD: begin
                w.acc_op = ACC_ADD_I;
            end
            STEP_MUL_D: begin
                w.cond   = C_SKIP_D;
                w.target = STEP_OUT;
                w.mul_en = 1'b1;
                w.mul_a  = MA_KD;
                w.mul_b  = MB_DI;
            end
            STEP_MUL_K: begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_PROD;
                w.mul_b  = MB_K1000;
            end
            STEP_DIV_D: begin
                w.div_start = 1'b1;
                w.div_den   = DEN_MS;
            end
            STEP_WAIT_D: begin
                w.cond = C_WAIT_DIV;
            end
            STEP_D_SUB: begin
                w.acc_op = ACC_SUB_Q;
            end
            STEP_OUT: begin
                w.cond     = C_WAIT_OUT;
                w.target   = STEP_LOAD;
                w.out_load = 1'b1;
            end
            STEP_INT_ZERO: begin
                w.cond   = C_JUMP;
                w.target = STEP_MUL_D;
                w.int_op = INT_ZERO;
            end
            default: begin
                w.cond   = C_JUMP;
                w.target = STEP_LOAD;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/pidc_div.sv -----
// ----------------------------------------------------------------------------
// pidc_div
// Iterative rounding divider: signed 64-bit numerator by unsigned 16-bit
// divisor, four quotient bits per cycle, ties rounded away from zero.
// ----------------------------------------------------------------------------
module pidc_div import pidc_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [WIDE_W-1:0] num,
    input  logic        [MS_W-1:0]   den,
    output logic                     busy,
    output logic signed [WIDE_W-1:0] quot
);

    typedef enum logic [3:0] {
        DV_IDLE = 4'b0001,
        DV_PREP = 4'b0010,
        DV_RUN  = 4'b0100,
        DV_FIX  = 4'b1000
    } div_state_t;

    div_state_t             state_reg, state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [WIDE_W-1:0]      work_reg, work_next;
    logic [MS_W-1:0]        rem_reg, rem_next;
    logic [MS_W-1:0]        den_reg;
    logic                   neg_reg;
    logic signed [WIDE_W-1:0] quot_reg;

    always_comb begin
        logic [MS_W:0]     r;
        logic [WIDE_W-1:0] n;
        r = {1'b0, rem_reg};
        n = work_reg;
        for (int k = 0; k < DIV_BITS; k++) begin
            r = {r[MS_W-1:0], n[WIDE_W-1]};
            n = {n[WIDE_W-2:0], 1'b0};
            if (r >= {1'b0, den_reg}) begin
                r    = r - {1'b0, den_reg};
                n[0] = 1'b1;
            end
        end
        work_next = n;
        rem_next  = r[MS_W-1:0];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            DV_IDLE: if (start) state_next = DV_PREP;
            DV_PREP: state_next = DV_RUN;
            DV_RUN:  if (cnt_reg == '0) state_next = DV_FIX;
            DV_FIX:  state_next = DV_IDLE;
            default: state_next = DV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            DV_IDLE: begin
                if (start) begin
                    work_reg <= num[WIDE_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
                    neg_reg  <= num[WIDE_W-1];
                    den_reg  <= den;
                end
            end
            DV_PREP: begin
                // bias by half the divisor for round to nearest
                work_reg <= work_reg + WIDE_W'(den_reg >> 1);
                rem_reg  <= '0;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
            end
            DV_RUN: begin
                work_reg <= work_next;
                rem_reg  <= rem_next;
                cnt_reg  <= cnt_reg - 1'b1;
            end
            DV_FIX: begin
                quot_reg <= neg_reg ? -$signed(work_reg) : $signed(work_reg);
            end
            default: ;
        endcase
    end

    assign busy = (state_reg != DV_IDLE);
    assign quot = quot_reg;

    a_no_zero_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == DV_RUN) |-> (den_reg != '0))
        else $error("divider running with zero divisor");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> (state_reg == DV_IDLE))
        else $error("divider started while busy");

endmodule

// ----- rtl/pidc_seq.sv -----
// ----------------------------------------------------------------------------
// pidc_seq
// Microcode sequencer: step counter, program ROM and conditional jumps.
// ----------------------------------------------------------------------------
module pidc_seq import pidc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  pidc_status_t status,
    output ctrl_word_t   cw
);

    logic [PC_W-1:0] pc_reg, pc_next;
    logic [PC_W-1:0] pc_inc;

    assign cw     = ucode_rom(pc_reg);
    assign pc_inc = pc_reg + PC_W'(1);

    always_comb begin
        unique case (cw.cond)
            C_NEXT:     pc_next = pc_inc;
            C_JUMP:     pc_next = cw.target;
            C_WAIT_IN:  pc_next = status.in_valid ? pc_inc : pc_reg;
            C_WAIT_DIV: pc_next = status.div_busy ? pc_reg : pc_inc;
            C_SKIP_KI:  pc_next = status.ki_zero ? cw.target : pc_inc;
            C_SKIP_D:   pc_next = status.d_skip ? cw.target : pc_inc;
            C_WAIT_OUT: pc_next = status.out_busy ? pc_reg : cw.target;
            default:    pc_next = STEP_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_LOAD;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ----- rtl/pidc_dp.sv -----
// ----------------------------------------------------------------------------
// pidc_dp
// Datapath: configuration registers, input latch, shared multiplier,
// accumulator, integral clamp and output register.
// ----------------------------------------------------------------------------
module pidc_dp import pidc_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [MEAS_W-1:0] s_measurement,
    input  logic signed [MEAS_W-1:0] s_target,
    input  logic        [MS_W-1:0]   s_elapsed_ms,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [MEAS_W-1:0] m_drive,
    output logic                     m_saturated,
    input  ctrl_word_t               cw,
    output pidc_status_t             status,
    output logic                     div_start,
    output logic signed [WIDE_W-1:0] div_num,
    output logic        [MS_W-1:0]   div_den,
    input  logic                     div_busy,
    input  logic signed [WIDE_W-1:0] div_quot
);

    logic signed [GAIN_W-1:0]  gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [LIM_W-1:0]   out_min_reg, out_max_reg;
    logic signed [Q_W-1:0]     integ_reg;
    logic signed [MEAS_W-1:0]  prev_reg;
    logic                      m_valid_reg;

    logic signed [ERR_W-1:0]   err_reg, di_reg;
    logic        [MS_W-1:0]    ms_reg;
    logic signed [WIDE_W-1:0]  prod_reg, acc_reg;
    logic signed [MEAS_W-1:0]  m_drive_reg;
    logic                      m_sat_reg;

    logic                      accept, out_load;
    logic signed [Q_W-1:0]     lo_q, hi_q;
    logic signed [WIDE_W-1:0]  lo_wide, hi_wide;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] product;
    logic signed [WIDE_W-1:0]  integ_ext, int_sum;
    logic signed [Q_W-1:0]     int_clamp;
    logic        [Q_W:0]       acc_low, acc_abs, rnd_mag;
    logic        [Q_W-FRAC_W:0] rnd_q, rnd_val;
    logic signed [MEAS_W-1:0]  drive_val;
    logic                      sat_val;

    assign accept   = cw.take_in && s_valid;
    assign out_load = cw.out_load && (!m_valid_reg || m_ready);

    assign lo_q    = {out_min_reg, {FRAC_W{1'b0}}};
    assign hi_q    = {out_max_reg, {FRAC_W{1'b0}}};
    assign lo_wide = {{(WIDE_W-Q_W){lo_q[Q_W-1]}}, lo_q};
    assign hi_wide = {{(WIDE_W-Q_W){hi_q[Q_W-1]}}, hi_q};

    always_comb begin
        unique case (cw.mul_a)
            MA_KP:   mul_a = MUL_A_W'(gain_p_reg);
            MA_KI:   mul_a = MUL_A_W'(gain_i_reg);
            MA_KD:   mul_a = MUL_A_W'(gain_d_reg);
            MA_PROD: mul_a = prod_reg[MUL_A_W-1:0];
            default: mul_a = '0;
        endcase
        unique case (cw.mul_b)
            MB_ERR:   mul_b = err_reg;
            MB_MS:    mul_b = {1'b0, ms_reg};
            MB_DI:    mul_b = di_reg;
            MB_K1000: mul_b = MUL_B_W'(MS_PER_S);
            default:  mul_b = '0;
        endcase
    end

    assign product = mul_a * mul_b;

    // integral update, clamped with the upper limit tested first
    assign integ_ext = {{(WIDE_W-Q_W){integ_reg[Q_W-1]}}, integ_reg};
    assign int_sum   = integ_ext + div_quot;

    always_comb begin
        if (int_sum > hi_wide) begin
            int_clamp = hi_q;
        end else if (int_sum < lo_wide) begin
            int_clamp = lo_q;
        end else begin
            int_clamp = int_sum[Q_W-1:0];
        end
    end

    // output: clamp or round Q16.16 to integer
    assign acc_low = {acc_reg[Q_W-1], acc_reg[Q_W-1:0]};
    assign acc_abs = acc_low[Q_W] ? (~acc_low + 1'b1) : acc_low;
    assign rnd_mag = acc_abs + (Q_W+1)'(ROUND_HALF);
    assign rnd_q   = rnd_mag[Q_W:FRAC_W];
    assign rnd_val = acc_low[Q_W] ? (~rnd_q + 1'b1) : rnd_q;

    always_comb begin
        if (acc_reg > hi_wide) begin
            drive_val = out_max_reg;
            sat_val   = 1'b1;
        end else if (acc_reg < lo_wide) begin
            drive_val = out_min_reg;
            sat_val   = 1'b1;
        end else begin
            drive_val = rnd_val[MEAS_W-1:0];
            sat_val   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg  <= GAIN_W'(65536);
            gain_i_reg  <= '0;
            gain_d_reg  <= '0;
            out_min_reg <= LIM_W'(16'h8000);
            out_max_reg <= LIM_W'(16'h7fff);
            integ_reg   <= '0;
            prev_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_GAIN_P:  gain_p_reg  <= cfg_wdata[GAIN_W-1:0];
                    REG_GAIN_I:  gain_i_reg  <= cfg_wdata[GAIN_W-1:0];
                    REG_GAIN_D:  gain_d_reg  <= cfg_wdata[GAIN_W-1:0];
                    REG_OUT_MIN: out_min_reg <= cfg_wdata[LIM_W-1:0];
                    REG_OUT_MAX: out_max_reg <= cfg_wdata[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                prev_reg <= s_measurement;
            end
            unique case (cw.int_op)
                INT_CLAMP: integ_reg <= int_clamp;
                INT_ZERO:  integ_reg <= '0;
                default: ;
            endcase
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            err_reg <= {s_target[MEAS_W-1], s_target}
                     - {s_measurement[MEAS_W-1], s_measurement};
            di_reg  <= {s_measurement[MEAS_W-1], s_measurement}
                     - {prev_reg[MEAS_W-1], prev_reg};
            ms_reg  <= s_elapsed_ms;
        end
        if (cw.mul_en) begin
            prod_reg <= product[WIDE_W-1:0];
        end
        unique case (cw.acc_op)
            ACC_LOAD_P: acc_reg <= prod_reg;
            ACC_ADD_I:  acc_reg <= acc_reg + integ_ext;
            ACC_SUB_Q:  acc_reg <= acc_reg - div_quot;
            default: ;
        endcase
        if (out_load) begin
            m_drive_reg <= drive_val;
            m_sat_reg   <= sat_val;
        end
    end

    assign s_ready     = cw.take_in;
    assign m_valid     = m_valid_reg;
    assign m_drive     = m_drive_reg;
    assign m_saturated = m_sat_reg;

    assign div_start = cw.div_start;
    assign div_num   = prod_reg;
    assign div_den   = (cw.div_den == DEN_MS) ? ms_reg : MS_W'(MS_PER_S);

    assign status.in_valid = s_valid;
    assign status.div_busy = div_busy;
    assign status.ki_zero  = (gain_i_reg == '0);
    assign status.d_skip   = (gain_d_reg == '0) || (ms_reg == '0);
    assign status.out_busy = m_valid_reg && !m_ready;

    a_integ_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cw.int_op == INT_CLAMP && out_min_reg <= out_max_reg)
        |-> (integ_reg >= lo_q && integ_reg <= hi_q))
        else $error("integral outside limits after clamp");

    a_drive_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_sat_reg)
        |-> (m_drive_reg >= out_min_reg && m_drive_reg <= out_max_reg))
        else $error("unsaturated drive outside limits");

endmodule

// ----- rtl/pid_controller_clamped.sv -----
// ----------------------------------------------------------------------------
// pid_controller_clamped
// PID controller with integral and output clamping, Q16.16 gains.
// ----------------------------------------------------------------------------
// One item at a time: each accepted item gives one result. The full path
// runs the microcode steps from load to output plus two divisions
// in the shared divider (integral scaled by 1/1000, derivative divided by
// the elapsed time); zero integral gain skips the first division, zero
// derivative gain or zero elapsed time skips the second. A new item is
// taken once the previous result has been loaded into the output register.
// No clearing pass after reset.
module pid_controller_clamped import pidc_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [MEAS_W-1:0] s_measurement,
    input  logic signed [MEAS_W-1:0] s_target,
    input  logic        [MS_W-1:0]   s_elapsed_ms,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [MEAS_W-1:0] m_drive,
    output logic                     m_saturated
);

    ctrl_word_t               cw;
    pidc_status_t             status;
    logic                     div_start, div_busy;
    logic signed [WIDE_W-1:0] div_num, div_quot;
    logic        [MS_W-1:0]   div_den;

    pidc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cw      (cw)
    );

    pidc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    pidc_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_measurement (s_measurement),
        .s_target      (s_target),
        .s_elapsed_ms  (s_elapsed_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_drive       (m_drive),
        .m_saturated   (m_saturated),
        .cw            (cw),
        .status        (status),
        .div_start     (div_start),
        .div_num       (div_num),
        .div_den       (div_den),
        .div_busy      (div_busy),
        .div_quot      (div_quot)
    );

endmodule
